// ===== hw/rtl/vma_pkg.sv =====
// Shared types and constants of the vector moving average unit.
package vma_pkg;

    // Lane count, sample width and window count width.
    localparam int LANES       = 8;
    localparam int SAMPLE_BITS = 16;
    localparam int CNT_W       = 7;
    // A lane total holds up to 127 samples without overflow.
    localparam int TOT_W       = SAMPLE_BITS + CNT_W;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic signed [TOT_W-1:0]       t_total;
    typedef logic [CNT_W-1:0]              t_count;

    // One history row: one sample for every lane.
    typedef logic [LANES-1:0][SAMPLE_BITS-1:0] t_row;

    typedef struct packed {
        t_sample sample_0;
        t_sample sample_1;
        t_sample sample_2;
        t_sample sample_3;
        t_sample sample_4;
        t_sample sample_5;
        t_sample sample_6;
        t_sample sample_7;
    } t_in;

    typedef struct packed {
        t_sample mean_0;
        t_sample mean_1;
        t_sample mean_2;
        t_sample mean_3;
        t_sample mean_4;
        t_sample mean_5;
        t_sample mean_6;
        t_sample mean_7;
        t_count  held_count;
    } t_out;

    // Control between the sequencer and the lane dividers.
    typedef struct packed {
        logic   start;
        t_count divisor;
    } t_div_ctrl;

    // Sign extension of one sample to the width of a lane total.
    function automatic t_total sext_sample(logic [SAMPLE_BITS-1:0] s);
        return {{(TOT_W - SAMPLE_BITS){s[SAMPLE_BITS-1]}}, s};
    endfunction

endpackage

// ===== hw/rtl/vma_history.sv =====
// History memory: one row of lane samples per window slot, registered read.
module vma_history
    import vma_pkg::*;
#(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  t_row              i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output t_row              o_rdata
);

    t_row r_mem [DEPTH];
    t_row r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/vma_divider.sv =====
// Radix-2 restoring dividers, one per lane, stepping together.
module vma_divider
    import vma_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_div_ctrl i_ctrl,
    input  t_total    i_dividend [LANES],
    output logic      o_busy,
    output t_sample   o_quot [LANES]
);

    localparam int STEP_W = $clog2(TOT_W + 1);

    logic [STEP_W-1:0] r_steps;
    logic [STEP_W-1:0] n_steps;
    t_count            r_div;

    // Shared step counter; the dividers shift in one dividend bit per cycle.
    always_comb begin
        n_steps = r_steps;
        if (i_ctrl.start) begin
            n_steps = STEP_W'(TOT_W);
        end else if (r_steps != '0) begin
            n_steps = r_steps - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps <= '0;
        end else begin
            r_steps <= n_steps;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_div <= i_ctrl.divisor;
        end
    end

    assign o_busy = (r_steps != '0);

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        logic [TOT_W-1:0] r_quo;
        t_count           r_rem;
        logic             r_neg;
        logic [CNT_W:0]   shifted;
        logic             fits;
        logic [TOT_W-1:0] signed_quo;

        // Shift in one dividend bit and subtract where the divisor fits.
        assign shifted = {r_rem, r_quo[TOT_W-1]};
        assign fits    = (shifted >= {1'b0, r_div});

        always_ff @(posedge i_clk) begin
            if (i_ctrl.start) begin
                r_neg <= i_dividend[g][TOT_W-1];
                r_quo <= i_dividend[g][TOT_W-1] ? (TOT_W)'(-i_dividend[g])
                                                : (TOT_W)'(i_dividend[g]);
                r_rem <= '0;
            end else if (o_busy) begin
                r_quo <= {r_quo[TOT_W-2:0], fits};
                r_rem <= fits ? CNT_W'(shifted - {1'b0, r_div})
                              : CNT_W'(shifted);
            end
        end

        // Restore the sign, which truncates toward zero.
        assign signed_quo = r_neg ? (~r_quo + 1'b1) : r_quo;
        assign o_quot[g]  = signed_quo[SAMPLE_BITS-1:0];
    end

endmodule

// ===== hw/rtl/vector_moving_average_unit.sv =====
// Vector moving average unit: a boxcar mean over up to 64 sample vectors.
// An accepted transaction passes the update, load and divide states; the input is
// stalled until the 23-step lane dividers have finished and the result is registered.
// The history row is read and written back once per transaction.
// Reset clears totals, fill count and write slot and sets the window to 50.
// The history memory is not cleared; entries are only used after a write.
module vector_moving_average_unit
    import vma_pkg::*;
#(
    parameter int MAX_WINDOW = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_wdata,
    input  logic             i_valid,
    output logic             o_stall,
    input  t_in              i_data,
    output logic             o_valid,
    input  logic             i_stall,
    output t_out             o_data
);

    localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CMP_W  = ((SLOT_W > CNT_W) ? SLOT_W : CNT_W) + 1;
    localparam int CAP    = (MAX_WINDOW < 127) ? MAX_WINDOW : 127;
    localparam logic [CNT_W-1:0] LEN_CAP = CNT_W'(CAP);
    localparam logic [CNT_W-1:0] WIN_RESET = CNT_W'(50);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_UPDATE = 4'b0010,
        S_LOAD   = 4'b0100,
        S_DIVIDE = 4'b1000
    } t_state;

    t_state            r_state, n_state;
    t_count            r_window;
    t_count            r_fill, n_fill;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic              r_full;
    t_row              r_samples;
    t_total            r_tot [LANES];
    t_total            n_tot [LANES];
    logic              r_out_valid;
    t_out              r_out;

    t_count            eff_len;
    t_row              in_row;
    t_row              old_row;
    logic              in_accept;
    logic              out_free;
    logic              mem_we;
    logic [CMP_W-1:0]  slot_inc;
    logic              div_busy;
    t_div_ctrl         div_ctrl;
    t_sample           quot [LANES];

    // Effective window: zero acts as one, large values clamp to the store depth.
    always_comb begin
        if (r_window == '0) begin
            eff_len = CNT_W'(1);
        end else if (r_window > LEN_CAP) begin
            eff_len = LEN_CAP;
        end else begin
            eff_len = r_window;
        end
    end

    // Input fields as a row of lanes.
    assign in_row[0] = i_data.sample_0;
    assign in_row[1] = i_data.sample_1;
    assign in_row[2] = i_data.sample_2;
    assign in_row[3] = i_data.sample_3;
    assign in_row[4] = i_data.sample_4;
    assign in_row[5] = i_data.sample_5;
    assign in_row[6] = i_data.sample_6;
    assign in_row[7] = i_data.sample_7;

    assign o_stall   = (r_state != S_IDLE);
    assign in_accept = i_valid && !o_stall;
    assign out_free  = !r_out_valid || !i_stall;
    assign mem_we    = (r_state == S_UPDATE);

    // History memory: read the slot on accept, write the new row back next cycle.
    vma_history #(
        .DEPTH  (MAX_WINDOW),
        .ADDR_W (SLOT_W)
    ) u_history (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_slot),
        .i_wdata (r_samples),
        .i_re    (in_accept),
        .i_raddr (r_slot),
        .o_rdata (old_row)
    );

    // Per-lane total update; the oldest sample leaves once the window is full.
    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            n_tot[k] = r_tot[k] + sext_sample(r_samples[k])
                       - (r_full ? sext_sample(old_row[k]) : t_total'(0));
        end
    end

    // Write slot advance with wraparound at the window length.
    assign slot_inc = CMP_W'(r_slot) + CMP_W'(1);

    always_comb begin
        n_slot = r_slot;
        n_fill = r_fill;
        if (r_state == S_UPDATE) begin
            n_slot = (slot_inc == CMP_W'(eff_len)) ? '0 : SLOT_W'(slot_inc);
            n_fill = r_full ? r_fill : r_fill + 1'b1;
        end
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (in_accept) n_state = S_UPDATE;
            S_UPDATE: n_state = S_LOAD;
            S_LOAD:   n_state = S_DIVIDE;
            S_DIVIDE: if (!div_busy && out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_window <= WIN_RESET;
            r_fill   <= '0;
            r_slot   <= '0;
            for (int k = 0; k < LANES; k++) begin
                r_tot[k] <= '0;
            end
        end else if (i_cfg_we) begin
            // A new window length restarts the filter.
            r_window <= i_cfg_wdata;
            r_fill   <= '0;
            r_slot   <= '0;
            for (int k = 0; k < LANES; k++) begin
                r_tot[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_slot  <= n_slot;
            if (r_state == S_UPDATE) begin
                r_tot <= n_tot;
            end
        end
    end

    // Captured samples and the full flag of the transaction in progress.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_samples <= in_row;
            r_full    <= (r_fill == eff_len);
        end
    end

    // Lane dividers start from the updated totals and fill count.
    assign div_ctrl.start   = (r_state == S_LOAD);
    assign div_ctrl.divisor = r_fill;

    vma_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (div_ctrl),
        .i_dividend (r_tot),
        .o_busy     (div_busy),
        .o_quot     (quot)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DIVIDE && !div_busy && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DIVIDE && !div_busy && out_free) begin
            r_out.mean_0     <= quot[0];
            r_out.mean_1     <= quot[1];
            r_out.mean_2     <= quot[2];
            r_out.mean_3     <= quot[3];
            r_out.mean_4     <= quot[4];
            r_out.mean_5     <= quot[5];
            r_out.mean_6     <= quot[6];
            r_out.mean_7     <= quot[7];
            r_out.held_count <= r_fill;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // The fill count never exceeds the effective window.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= eff_len)
        else $error("fill count above window length");

    // The write slot stays inside the window.
    a_slot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_slot) < CMP_W'(eff_len))
        else $error("write slot outside window");

    // Starting the dividers makes them busy in the next cycle.
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD && !i_cfg_we) |=> div_busy)
        else $error("dividers did not start");

    // A new result appears only after the dividers have finished.
    a_out_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DIVIDE && !div_busy))
        else $error("result loaded before division finished");

endmodule
